>>> rtl/u8u16_pkg.sv
`timescale 1ns / 1ps
package u8u16_pkg;

  localparam int WordW  = 16;
  localparam int PointW = 21;

  localparam logic [15:0] CapReset  = 16'd256;
  localparam logic [7:0]  ContMask  = 8'hC0;
  localparam logic [7:0]  ContCode  = 8'h80;
  localparam logic [7:0]  Lead2Mask = 8'hE0;
  localparam logic [7:0]  Lead2Code = 8'hC0;
  localparam logic [7:0]  Lead3Mask = 8'hF0;
  localparam logic [7:0]  Lead3Code = 8'hE0;
  localparam logic [7:0]  Lead4Mask = 8'hF8;
  localparam logic [7:0]  Lead4Code = 8'hF0;
  localparam logic [PointW-1:0] SuppBase = 21'h10000;
  localparam logic [15:0] HiSurr = 16'hD800;
  localparam logic [15:0] LoSurr = 16'hDC00;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
    logic [WordW-1:0] count;
  } out_word_t;

  typedef struct packed {
    logic [1:0]        pending;
    logic [PointW-1:0] partial;
    logic [WordW-1:0]  written;
    logic              stopped;
  } dec_state_t;

endpackage

>>> rtl/u8u16_decode.sv
`timescale 1ns / 1ps
module u8u16_decode (
  input  logic [7:0]              in_byte,
  input  logic [15:0]             cap_words,
  input  u8u16_pkg::dec_state_t   cur,
  output u8u16_pkg::dec_state_t   nxt,
  output logic [1:0]              num_words,
  output u8u16_pkg::out_word_t    word0,
  output u8u16_pkg::out_word_t    word1
);
  import u8u16_pkg::*;

  logic [PointW-1:0] grown;
  logic [PointW-1:0] point;
  logic [PointW-1:0] supp;
  logic              do_emit;
  logic              is_cont;
  logic              room1;
  logic              room2;

  assign is_cont = (in_byte & ContMask) == ContCode;
  assign grown   = {cur.partial[PointW-7:0], in_byte[5:0]};
  assign supp    = point - SuppBase;
  assign room1   = ({1'b0, cur.written} + 17'd1) < {1'b0, cap_words};
  assign room2   = ({1'b0, cur.written} + 17'd2) < {1'b0, cap_words};

  always_comb begin
    nxt       = cur;
    num_words = 2'd0;
    word0     = '0;
    word1     = '0;
    do_emit   = 1'b0;
    point     = '0;
    if (in_byte == 8'd0) begin
      num_words   = 2'd1;
      word0.last  = 1'b1;
      word0.count = cur.written;
      nxt         = '0;
    end else if (!cur.stopped) begin
      if (cur.pending != 2'd0 && is_cont) begin
        nxt.partial = grown;
        nxt.pending = cur.pending - 2'd1;
        if (cur.pending == 2'd1) begin
          do_emit = 1'b1;
          point   = grown;
        end
      end else begin
        nxt.pending = 2'd0;
        nxt.partial = '0;
        if (!room1) begin
          nxt.stopped = 1'b1;
        end else if (in_byte[7] == 1'b0) begin
          do_emit = 1'b1;
          point   = {13'd0, in_byte};
        end else if ((in_byte & Lead2Mask) == Lead2Code) begin
          nxt.partial = {16'd0, in_byte[4:0]};
          nxt.pending = 2'd1;
        end else if ((in_byte & Lead3Mask) == Lead3Code) begin
          nxt.partial = {17'd0, in_byte[3:0]};
          nxt.pending = 2'd2;
        end else if ((in_byte & Lead4Mask) == Lead4Code) begin
          nxt.partial = {18'd0, in_byte[2:0]};
          nxt.pending = 2'd3;
        end
      end
      if (do_emit) begin
        if (point[PointW-1:16] == '0) begin
          num_words   = 2'd1;
          word0.word  = point[15:0];
          nxt.written = cur.written + 16'd1;
        end else if (room2) begin
          num_words   = 2'd2;
          word0.word  = HiSurr | {5'd0, supp[20:10]};
          word1.word  = LoSurr | {6'd0, supp[9:0]};
          nxt.written = cur.written + 16'd2;
        end else begin
          nxt.stopped = 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/utf8_to_utf16_stream.sv
`timescale 1ns / 1ps
// UTF-8 to UTF-16 stream transcoder.
// Slave stream: one UTF-8 byte per item on s_tdata; a zero byte ends the string.
// Master stream: one UTF-16 word per item. m_tdata[15:0] is the word,
// m_tdata[31:16] the count of words written, nonzero only on the terminator;
// m_tlast marks the zero terminator word that closes each string.
// cfg channel: writes cap_words (output capacity in words, terminator included);
// cfg_ready is always high; write only while the block is idle.
// Each byte is decoded in the cycle it is accepted and its words are
// registered into a small output queue, from which they are offered in order.
// Throughput is one byte per cycle while s_tready is high; a 4-byte sequence yields two words, and
// the three bytes before it produce none, so with a ready receiver the queue
// never holds more than two words and the input never stalls.
// s_tready drops only when the queue lacks room for two words, so a stalled
// receiver holds the queue contents and back-pressures the input.
// Synchronous reset empties the queue, clears decoder state and sets
// cap_words to 256.
module utf8_to_utf16_stream #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // utf16_word, word_count
  output logic        m_tlast,   // is_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import u8u16_pkg::*;

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] ReadyMax = CntW'(FIFO_DEPTH - 2);

  logic [15:0] cap_words;
  dec_state_t  state;
  dec_state_t  state_next;
  logic [1:0]  num_words;
  out_word_t   word0;
  out_word_t   word1;

  out_word_t       queue [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] wr_ptr1;
  logic [PtrW-1:0] wr_ptr2;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            take;
  logic            push;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  u8u16_decode u_decode (
    .in_byte   (s_tdata),
    .cap_words (cap_words),
    .cur       (state),
    .nxt       (state_next),
    .num_words (num_words),
    .word0     (word0),
    .word1     (word1)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = fill <= ReadyMax;
  assign take      = s_tvalid && s_tready;
  assign push      = take && (num_words != 2'd0);
  assign m_tvalid  = fill != '0;
  assign pop       = m_tvalid && m_tready;
  assign wr_ptr1   = ptr_inc(wr_ptr);
  assign wr_ptr2   = ptr_inc(wr_ptr1);

  assign m_tdata = {queue[rd_ptr].count, queue[rd_ptr].word};
  assign m_tlast = queue[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_words <= CapReset;
    end else if (cfg_valid) begin
      cap_words <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (take) begin
        state <= state_next;
      end
      if (push) begin
        wr_ptr <= (num_words == 2'd2) ? wr_ptr2 : wr_ptr1;
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      fill <= fill + (push ? CntW'(num_words) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= word0;
      if (num_words == 2'd2) begin
        queue[wr_ptr1] <= word1;
      end
    end
  end

endmodule
